FILE: hdl/lsci_pkg.sv
package lsci_pkg;

    // Field and datapath widths
    localparam int COORD_W = 16;
    localparam int R2_W    = 33;
    localparam int T_W     = 17;
    localparam int A_W     = 35;   // a = dx^2 + dy^2
    localparam int H_W     = 36;   // h = ax*dx + ay*dy, signed
    localparam int D_W     = 70;   // discriminant h^2 - a*c
    localparam int S_W     = 35;   // floor square root of the discriminant
    localparam int N_W     = 37;   // -h +/- s, signed
    localparam int U_W     = 36;   // magnitude of -h +/- s

    localparam int SQ_STEPS  = 35;
    localparam int DIV_STEPS = 17;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    localparam logic [T_W-1:0] T_ONE = 17'd65536;

    // Per-item flags and operands carried beside the square root
    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  early;   // both ends strictly on one side
        logic                  azero;   // zero-length segment
        logic                  dneg;    // negative discriminant
    } lsci_side_t;

    // Per-item flags carried beside the dividers
    typedef struct packed {
        logic early;
        logic azero;
        logic dneg;
        logic szero;
        logic neg1;
        logic neg2;
    } lsci_tail_t;

endpackage

FILE: hdl/lsci_front.sv
module lsci_front
    import lsci_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic signed [COORD_W-1:0]  start_x,
    input  logic signed [COORD_W-1:0]  start_y,
    input  logic signed [COORD_W-1:0]  end_x,
    input  logic signed [COORD_W-1:0]  end_y,
    input  logic signed [COORD_W-1:0]  centre_x,
    input  logic signed [COORD_W-1:0]  centre_y,
    input  logic [R2_W-1:0]            radius_squared,
    output logic                       out_vld,
    output logic [D_W-1:0]             d,
    output lsci_side_t                 side
);

    // Stage 1: move the centre to the origin
    logic                vld1_reg;
    logic signed [16:0]  ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [17:0]  dx1_reg, dy1_reg;
    logic [R2_W-1:0]     r2_1_reg;

    // Stage 2: squares and cross products
    logic                vld2_reg;
    logic [31:0]         ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic [33:0]         dx2_reg, dy2_reg;
    logic signed [34:0]  axdx_reg, aydy_reg;
    logic [R2_W-1:0]     r2_2_reg;
    logic signed [33:0]  ax_sq, ay_sq, bx_sq, by_sq;
    logic signed [35:0]  dx_sq, dy_sq;
    logic signed [34:0]  axdx_p, aydy_p;

    // Stage 3: distances, a and h
    logic                vld3_reg;
    logic [32:0]         ra2_reg, rb2_reg;
    logic [A_W-1:0]      a3_reg;
    logic signed [H_W-1:0] h3_reg;
    logic [R2_W-1:0]     r2_3_reg;

    // Stage 4: side test and magnitudes
    logic                vld4_reg;
    logic [33:0]         habs_reg;
    logic [32:0]         cabs_reg;
    logic                cle0_reg;
    lsci_side_t          side4_reg;
    logic                early_next;
    logic [33:0]         habs_next;

    // Stage 5: partial products
    logic                vld5_reg;
    logic [33:0]         hll_reg, hlh_reg, hhh_reg;
    logic [33:0]         cll_reg;
    logic [32:0]         clh_reg;
    logic [34:0]         chl_reg;
    logic [33:0]         chh_reg;
    logic                cle0_5_reg;
    lsci_side_t          side5_reg;

    // Stage 6: h^2 and a*|c|
    logic                vld6_reg;
    logic [67:0]         hh_reg, ac_reg;
    logic                cle0_6_reg;
    lsci_side_t          side6_reg;

    // Stage 7: discriminant
    logic                vld7_reg;
    logic [D_W-1:0]      d7_reg;
    lsci_side_t          side7_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
        end
    end

    // Products feeding stage 2
    assign ax_sq  = ax1_reg * ax1_reg;
    assign ay_sq  = ay1_reg * ay1_reg;
    assign bx_sq  = bx1_reg * bx1_reg;
    assign by_sq  = by1_reg * by1_reg;
    assign dx_sq  = dx1_reg * dx1_reg;
    assign dy_sq  = dy1_reg * dy1_reg;
    assign axdx_p = ax1_reg * dx1_reg;
    assign aydy_p = ay1_reg * dy1_reg;

    // Side test feeding stage 4
    assign early_next = ((ra2_reg > r2_3_reg) && (rb2_reg > r2_3_reg))
                     || ((ra2_reg < r2_3_reg) && (rb2_reg < r2_3_reg));
    assign habs_next  = h3_reg[H_W-1] ? 34'(-h3_reg) : 34'(h3_reg);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg  <= 17'(start_x) - 17'(centre_x);
            ay1_reg  <= 17'(start_y) - 17'(centre_y);
            bx1_reg  <= 17'(end_x) - 17'(centre_x);
            by1_reg  <= 17'(end_y) - 17'(centre_y);
            dx1_reg  <= 18'(end_x) - 18'(start_x);
            dy1_reg  <= 18'(end_y) - 18'(start_y);
            r2_1_reg <= radius_squared;

            ax2_reg  <= ax_sq[31:0];
            ay2_reg  <= ay_sq[31:0];
            bx2_reg  <= bx_sq[31:0];
            by2_reg  <= by_sq[31:0];
            dx2_reg  <= dx_sq[33:0];
            dy2_reg  <= dy_sq[33:0];
            axdx_reg <= axdx_p;
            aydy_reg <= aydy_p;
            r2_2_reg <= r2_1_reg;

            ra2_reg  <= 33'(ax2_reg) + 33'(ay2_reg);
            rb2_reg  <= 33'(bx2_reg) + 33'(by2_reg);
            a3_reg   <= 35'(dx2_reg) + 35'(dy2_reg);
            h3_reg   <= 36'(axdx_reg) + 36'(aydy_reg);
            r2_3_reg <= r2_2_reg;

            habs_reg        <= habs_next;
            cle0_reg        <= (r2_3_reg >= ra2_reg);
            cabs_reg        <= (r2_3_reg >= ra2_reg) ? (r2_3_reg - ra2_reg)
                                                     : (ra2_reg - r2_3_reg);
            side4_reg.h     <= h3_reg;
            side4_reg.a     <= a3_reg;
            side4_reg.early <= early_next;
            side4_reg.azero <= (a3_reg == '0);
            side4_reg.dneg  <= 1'b0;

            hll_reg    <= 34'(habs_reg[16:0]) * 34'(habs_reg[16:0]);
            hlh_reg    <= 34'(habs_reg[16:0]) * 34'(habs_reg[33:17]);
            hhh_reg    <= 34'(habs_reg[33:17]) * 34'(habs_reg[33:17]);
            cll_reg    <= 34'(side4_reg.a[16:0]) * 34'(cabs_reg[16:0]);
            clh_reg    <= 33'(side4_reg.a[16:0]) * 33'(cabs_reg[32:17]);
            chl_reg    <= 35'(side4_reg.a[34:17]) * 35'(cabs_reg[16:0]);
            chh_reg    <= 34'(side4_reg.a[34:17]) * 34'(cabs_reg[32:17]);
            cle0_5_reg <= cle0_reg;
            side5_reg  <= side4_reg;

            hh_reg     <= 68'(hll_reg) + (68'(hlh_reg) << 18) + (68'(hhh_reg) << 34);
            ac_reg     <= 68'(cll_reg) + (68'(clh_reg) << 17) + (68'(chl_reg) << 17)
                        + (68'(chh_reg) << 34);
            cle0_6_reg <= cle0_5_reg;
            side6_reg  <= side5_reg;

            d7_reg          <= cle0_6_reg ? (70'(hh_reg) + 70'(ac_reg))
                                          : (70'(hh_reg) - 70'(ac_reg));
            side7_reg.h     <= side6_reg.h;
            side7_reg.a     <= side6_reg.a;
            side7_reg.early <= side6_reg.early;
            side7_reg.azero <= side6_reg.azero;
            side7_reg.dneg  <= !cle0_6_reg && (hh_reg < ac_reg);
        end
    end

    assign out_vld = vld7_reg;
    assign d       = d7_reg;
    assign side    = side7_reg;

endmodule

FILE: hdl/lsci_sqrt.sv
module lsci_sqrt
    import lsci_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_vld,
    input  logic [D_W-1:0]  d,
    input  lsci_side_t      in_side,
    output logic            out_vld,
    output logic [S_W-1:0]  s,
    output lsci_side_t      out_side
);

    logic [D_W-1:0] num_reg  [SQ_STEPS];
    logic [D_W-1:0] res_reg  [SQ_STEPS];
    lsci_side_t     side_reg [SQ_STEPS];
    logic           vld_reg  [SQ_STEPS];

    // One result bit per stage, most significant first
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam logic [D_W-1:0] BIT = D_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [D_W-1:0] num_in, res_in, trial, num_nx, res_nx;
        lsci_side_t     side_in;
        logic           vld_in, take;

        if (k == 0)
        begin : g_first
            assign num_in  = d;
            assign res_in  = '0;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end
        else
        begin : g_next
            assign num_in  = num_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // Try the next bit and keep it when the remainder allows
        always_comb
        begin
            trial  = res_in + BIT;
            take   = (num_in >= trial);
            num_nx = take ? (num_in - trial) : num_in;
            res_nx = take ? ((res_in >> 1) + BIT) : (res_in >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k]  <= num_nx;
                res_reg[k]  <= res_nx;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[SQ_STEPS-1];
    assign s        = res_reg[SQ_STEPS-1][S_W-1:0];
    assign out_side = side_reg[SQ_STEPS-1];

endmodule

FILE: hdl/lsci_div.sv
module lsci_div
    import lsci_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [U_W-1:0]  u,
    input  logic [A_W-1:0]  a,
    output logic [T_W-1:0]  q,
    output logic            ovf
);

    // Range check: the quotient fits 17 bits only when u < 2a
    logic [U_W-1:0] r_pre_reg;
    logic [A_W-1:0] a_pre_reg;
    logic           ovf_pre_reg;

    logic [U_W-1:0] r_reg   [DIV_STEPS];
    logic [A_W-1:0] a_reg   [DIV_STEPS];
    logic [T_W-1:0] q_reg   [DIV_STEPS];
    logic           ovf_reg [DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_pre_reg   <= u;
            a_pre_reg   <= a;
            ovf_pre_reg <= (u >= {a, 1'b0});
        end
    end

    // One quotient bit per stage of (u * 2^16) / a
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        logic [U_W-1:0] r_in, r_sub;
        logic [A_W-1:0] a_in;
        logic [T_W-1:0] q_in;
        logic           ovf_in, take;

        if (j == 0)
        begin : g_first
            assign r_in   = r_pre_reg;
            assign a_in   = a_pre_reg;
            assign q_in   = '0;
            assign ovf_in = ovf_pre_reg;
        end
        else
        begin : g_next
            assign r_in   = r_reg[j-1];
            assign a_in   = a_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign ovf_in = ovf_reg[j-1];
        end

        always_comb
        begin
            take  = (r_in >= U_W'(a_in));
            r_sub = take ? (r_in - U_W'(a_in)) : r_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= r_sub << 1;
                a_reg[j]   <= a_in;
                q_reg[j]   <= {q_in[T_W-2:0], take};
                ovf_reg[j] <= ovf_in;
            end
        end
    end

    assign q   = q_reg[DIV_STEPS-1];
    assign ovf = ovf_reg[DIV_STEPS-1];

endmodule

FILE: hdl/line_segment_circle_intersect_unit.sv
// Throughput: one item per cycle while the output is not stalled; 7 setup
// stages, a 35-stage square root, and two 18-stage dividers in parallel,
// all advancing together.
// A stall on the output holds every stage; the input is ready whenever the
// output register is empty or being taken.
// Reset (rst_n low, asynchronous) clears all valid bits; payload is not reset.
module line_segment_circle_intersect_unit
    import lsci_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
    // centre_x[79:64], centre_y[95:80], radius_squared[128:96], zero[135:129]
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found[0], crossing_t[17:1], zero[23:18]
    output logic [23:0]  m_axis_tdata
);

    logic               adv;
    logic               front_vld, sq_vld;
    logic [D_W-1:0]     d;
    lsci_side_t         front_side, sq_side;
    logic [S_W-1:0]     s;

    // Stage A: both numerators
    logic               vlda_reg;
    logic signed [N_W-1:0] n1_reg, n2_reg;
    logic               szero_reg;
    lsci_side_t         sidea_reg;

    // Stage B: magnitudes and signs
    logic               vldb_reg;
    logic [U_W-1:0]     u1_reg, u2_reg;
    logic [A_W-1:0]     ab_reg;
    lsci_tail_t         tailb_reg;

    // Flags waiting beside the dividers
    logic               vldt_reg  [DIV_LAT];
    lsci_tail_t         tailt_reg [DIV_LAT];

    logic [T_W-1:0]     q1, q2;
    logic               ovf1, ovf2;

    // Output register
    logic               out_vld_reg;
    logic               found_reg, found_next;
    logic [T_W-1:0]     t_reg, t_next;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    lsci_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .in_vld         (s_axis_tvalid),
        .start_x        (s_axis_tdata[15:0]),
        .start_y        (s_axis_tdata[31:16]),
        .end_x          (s_axis_tdata[47:32]),
        .end_y          (s_axis_tdata[63:48]),
        .centre_x       (s_axis_tdata[79:64]),
        .centre_y       (s_axis_tdata[95:80]),
        .radius_squared (s_axis_tdata[128:96]),
        .out_vld        (front_vld),
        .d              (d),
        .side           (front_side)
    );

    lsci_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (front_vld),
        .d        (d),
        .in_side  (front_side),
        .out_vld  (sq_vld),
        .s        (s),
        .out_side (sq_side)
    );

    // Advance valid bits of the tail stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlda_reg <= 1'b0;
            vldb_reg <= 1'b0;
        end
        else if (adv)
        begin
            vlda_reg <= sq_vld;
            vldb_reg <= vlda_reg;
        end
    end

    // Form -h + s and -h - s, then split into sign and magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg    <= -N_W'(sq_side.h) + N_W'(s);
            n2_reg    <= -N_W'(sq_side.h) - N_W'(s);
            szero_reg <= (s == '0);
            sidea_reg <= sq_side;

            u1_reg          <= n1_reg[N_W-1] ? U_W'(-n1_reg) : U_W'(n1_reg);
            u2_reg          <= n2_reg[N_W-1] ? U_W'(-n2_reg) : U_W'(n2_reg);
            ab_reg          <= sidea_reg.a;
            tailb_reg.early <= sidea_reg.early;
            tailb_reg.azero <= sidea_reg.azero;
            tailb_reg.dneg  <= sidea_reg.dneg;
            tailb_reg.szero <= szero_reg;
            tailb_reg.neg1  <= n1_reg[N_W-1];
            tailb_reg.neg2  <= n2_reg[N_W-1];
        end
    end

    lsci_div u_div1 (
        .clk (clk),
        .en  (adv),
        .u   (u1_reg),
        .a   (ab_reg),
        .q   (q1),
        .ovf (ovf1)
    );

    lsci_div u_div2 (
        .clk (clk),
        .en  (adv),
        .u   (u2_reg),
        .a   (ab_reg),
        .q   (q2),
        .ovf (ovf2)
    );

    // Delay flags to meet the quotients
    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_tail
        logic       vld_in;
        lsci_tail_t tail_in;

        if (k == 0)
        begin : g_first
            assign vld_in  = vldb_reg;
            assign tail_in = tailb_reg;
        end
        else
        begin : g_next
            assign vld_in  = vldt_reg[k-1];
            assign tail_in = tailt_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vldt_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vldt_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tailt_reg[k] <= tail_in;
            end
        end
    end

    // Pick the first root inside [0,1]
    always_comb
    begin
        lsci_tail_t tl;
        logic       ok1, ok2;
        tl  = tailt_reg[DIV_LAT-1];
        ok1 = tl.neg1 ? ((q1 == '0) && !ovf1) : (!ovf1 && (q1 <= T_ONE));
        ok2 = tl.neg2 ? ((q2 == '0) && !ovf2) : (!ovf2 && (q2 <= T_ONE));
        found_next = 1'b0;
        t_next     = '0;
        if (tl.early)
        begin
            found_next = 1'b0;
        end
        else if (tl.azero)
        begin
            found_next = 1'b1;
        end
        else if (tl.dneg)
        begin
            found_next = 1'b0;
        end
        else if (tl.szero)
        begin
            // tangent: saturate -h/a into [0,1]
            found_next = 1'b1;
            if (tl.neg2)
                t_next = '0;
            else if (ovf2 || (q2 > T_ONE))
                t_next = T_ONE;
            else
                t_next = q2;
        end
        else if (ok2)
        begin
            found_next = 1'b1;
            t_next     = tl.neg2 ? '0 : q2;
        end
        else if (ok1)
        begin
            found_next = 1'b1;
            t_next     = tl.neg1 ? '0 : q1;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vldt_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= found_next;
            t_reg     <= t_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'b0, t_reg, found_reg};

endmodule

FILE: hdl/lsci_check.sv
module lsci_check
    import lsci_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    // A report without a crossing carries a zero parameter
    a_zero_when_missed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[17:1] == '0))
        else $error("crossing_t nonzero without a crossing");

    // Parameter never exceeds one
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:1] <= T_ONE))
        else $error("crossing_t above 1.0");

    // A blocked output stalls the input side
    a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input ready while output stalled");

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output item changed under stall");

endmodule

bind line_segment_circle_intersect_unit lsci_check u_lsci_check (.*);

FILE: test/line_segment_circle_intersect_unit_tb.sv
module line_segment_circle_intersect_unit_tb;
    import lsci_pkg::*;

    // Segment and circle as presented at the input stream
    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [32:0]        r2;
    } seg_t;

    // Crossing report expected at the output stream
    typedef struct {
        logic        found;
        logic [16:0] t;
    } crossing_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;

    seg_t      pending_segs[$];
    crossing_t crossings_due[$];
    int        error_count;
    int        segs_sent;
    int        crossings_seen;
    int        found_seen;
    bit        stim_done;
    bit        calm;

    line_segment_circle_intersect_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // Floor square root of a nonnegative value by bisection
    function automatic longint unsigned floor_sqrt(logic [71:0] v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        logic [71:0]     sq;
        lo = 0;
        hi = 64'd1 << 35;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            sq = 72'(mid) * 72'(mid);
            if (sq <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Work out the first crossing of segment and circle
    function automatic crossing_t first_crossing(seg_t g);
        crossing_t          r;
        longint             ax, ay, bx, by, r2, ra2, rb2, dx, dy, a, h, c, s, t1, t2, t;
        logic signed [79:0] disc;
        r.found = 0;
        r.t = '0;
        ax = longint'(g.sx) - longint'(g.cx);
        ay = longint'(g.sy) - longint'(g.cy);
        bx = longint'(g.ex) - longint'(g.cx);
        by = longint'(g.ey) - longint'(g.cy);
        r2 = longint'({31'd0, g.r2});
        ra2 = ax * ax + ay * ay;
        rb2 = bx * bx + by * by;
        if ((ra2 > r2 && rb2 > r2) || (ra2 < r2 && rb2 < r2))
            return r;
        dx = bx - ax;
        dy = by - ay;
        a = dx * dx + dy * dy;
        h = ax * dx + ay * dy;
        c = ra2 - r2;
        if (a == 0)
        begin
            r.found = 1;
            return r;
        end
        disc = 80'(h) * 80'(h) - 80'(a) * 80'(c);
        if (disc < 0)
            return r;
        if (disc == 0)
        begin
            t = (-h * 65536) / a;
            r.found = 1;
        end
        else
        begin
            s = longint'(floor_sqrt(72'(disc)));
            t1 = ((-h + s) * 65536) / a;
            t2 = ((-h - s) * 65536) / a;
            t = 0;
            if (t2 >= 0 && t2 <= 65536)
            begin
                r.found = 1;
                t = t2;
            end
            else if (t1 >= 0 && t1 <= 65536)
            begin
                r.found = 1;
                t = t1;
            end
        end
        if (t < 0)
            t = 0;
        if (t > 65536)
            t = 65536;
        if (r.found)
            r.t = 17'(t);
        return r;
    endfunction

    function automatic seg_t make_seg(int sx, int sy, int ex, int ey, int cx, int cy,
                                      longint r2);
        seg_t g;
        g.sx = 16'(sx);
        g.sy = 16'(sy);
        g.ex = 16'(ex);
        g.ey = 16'(ey);
        g.cx = 16'(cx);
        g.cy = 16'(cy);
        g.r2 = 33'(r2);
        return g;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1024)) - 512);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 65534)) - 32767);
        endcase
    endfunction

    // Random segment, mostly placed so that one end is near the circle
    function automatic seg_t rand_seg();
        seg_t           g;
        longint         ax, ay, d2;
        g.cx = rand_coord();
        g.cy = rand_coord();
        g.sx = rand_coord();
        g.sy = rand_coord();
        g.ex = rand_coord();
        g.ey = rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            g.r2 = 33'({$urandom, $urandom});
        end
        else
        begin
            ax = longint'(g.sx) - longint'(g.cx);
            ay = longint'(g.sy) - longint'(g.cy);
            d2 = ax * ax + ay * ay;
            if ($urandom_range(0, 1))
            begin
                ax = longint'(g.ex) - longint'(g.cx);
                ay = longint'(g.ey) - longint'(g.cy);
                d2 = ax * ax + ay * ay;
            end
            d2 = d2 + longint'($urandom_range(0, 64)) - 32;
            if (d2 < 0)
                d2 = 0;
            g.r2 = 33'(d2);
        end
        return g;
    endfunction

    // Directed cases, then random segments
    initial
    begin
        clk = 0;
        rst_n = 0;
        stim_done = 0;
        error_count = 0;
        pending_segs.push_back(make_seg(-100, 0, 100, 0, 0, 0, 50 * 50));
        pending_segs.push_back(make_seg(0, 0, 10, 0, 0, 0, 1000));
        pending_segs.push_back(make_seg(-500, 0, 500, 0, 0, 0, 100));
        pending_segs.push_back(make_seg(0, 30, 0, 30, 0, 0, 900));
        pending_segs.push_back(make_seg(0, 30, 0, 30, 0, 0, 901));
        pending_segs.push_back(make_seg(-100, 10, 100, 10, 0, 0, 100));
        pending_segs.push_back(make_seg(-100, 20, 100, 10, 0, 0, 200));
        pending_segs.push_back(make_seg(10, 0, -10, 0, 0, 0, 100));
        pending_segs.push_back(make_seg(0, 0, 100, 0, 0, 0, 0));
        pending_segs.push_back(make_seg(-32768, -32768, 32767, 32767, 0, 0, 64'h1ffffffff));
        pending_segs.push_back(make_seg(-32768, -32768, 32767, 32767, 32767, -32768, 0));
        pending_segs.push_back(make_seg(32767, 32767, -32768, -32768, -32768, 32767,
                                        64'h100000000));
        pending_segs.push_back(make_seg(-32768, 0, 32767, 0, 0, 0, 32768 * 32768));
        pending_segs.push_back(make_seg(32767, -1, -32768, -1, -32768, -32768, 1));
        pending_segs.push_back(make_seg(5, 5, 5, 5, 5, 5, 0));
        pending_segs.push_back(make_seg(0, 0, 3, 4, 0, 0, 25));
        pending_segs.push_back(make_seg(-7, 3, 9, -2, 1, 1, 30));
        for (int i = 0; i < 650; i++)
            pending_segs.push_back(rand_seg());
        repeat (5) @(posedge clk);
        rst_n <= 1;
        stim_done = 1;
    end

    // Drive segments, idling at random outside the calm stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
            segs_sent <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                crossings_due.push_back(first_crossing(pending_segs[0]));
                void'(pending_segs.pop_front());
                segs_sent <= segs_sent + 1;
            end
            if ((!s_axis_tvalid || s_axis_tready) && pending_segs.size() > 0
                && !(s_axis_tvalid && s_axis_tready && pending_segs.size() == 0))
            begin
                if (calm || $urandom_range(0, 99) >= 22)
                begin
                    s_axis_tvalid <= 1;
                    s_axis_tdata <= {7'd0, pending_segs[0].r2, pending_segs[0].cy,
                                     pending_segs[0].cx, pending_segs[0].ey,
                                     pending_segs[0].ex, pending_segs[0].sy,
                                     pending_segs[0].sx};
                end
                else
                    s_axis_tvalid <= 0;
            end
            else if (s_axis_tvalid && s_axis_tready)
                s_axis_tvalid <= 0;
        end
    end

    assign calm = (segs_sent >= 250 && segs_sent < 400);

    // Check crossing reports, stalling at random
    always @(posedge clk or negedge rst_n)
    begin
        crossing_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 0;
            crossings_seen <= 0;
            found_seen <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                crossings_seen <= crossings_seen + 1;
                if (crossings_due.size() == 0)
                begin
                    $display("%0t: unexpected item, actual found=%0d t=%0d", $time,
                             m_axis_tdata[0], m_axis_tdata[17:1]);
                    error_count++;
                end
                else
                begin
                    want = crossings_due.pop_front();
                    if (want.found)
                        found_seen <= found_seen + 1;
                    if (m_axis_tdata[0] !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %0d actual %0d", $time,
                                 want.found, m_axis_tdata[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[17:1] !== want.t)
                    begin
                        $display("%0t: crossing_t mismatch, expected %0d actual %0d",
                                 $time, want.t, m_axis_tdata[17:1]);
                        error_count++;
                    end
                    if (m_axis_tdata[23:18] !== 6'd0)
                    begin
                        $display("%0t: pad bits mismatch, expected 0 actual %0h", $time,
                                 m_axis_tdata[23:18]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= calm || $urandom_range(0, 99) >= 22;
        end
    end

    // Wait for all reports to drain, then give the verdict
    initial
    begin
        wait (stim_done);
        wait (pending_segs.size() == 0 && !s_axis_tvalid);
        wait (crossings_due.size() == 0);
        repeat (100) @(posedge clk);
        $display("sent %0d segments, checked %0d reports, %0d with a crossing",
                 segs_sent, crossings_seen, found_seen);
        if (error_count == 0 && crossings_due.size() == 0)
            $display("line_segment_circle_intersect_unit_tb: done, clean");
        else
            $display("line_segment_circle_intersect_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d reports outstanding", crossings_due.size());
        $display("line_segment_circle_intersect_unit_tb: done, errors");
        $finish;
    end

endmodule
